// ===== design/p24_pkg.sv =====
package p24_pkg;

    // Field widths
    localparam int BLOCK_W = 24;
    localparam int KEY_W   = 24;
    localparam int KS_W    = 80;
    localparam int RC_W    = 5;

    // 4-bit substitution box and its inverse
    localparam logic [3:0] SBOX_FWD [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    // Output bit j takes input bit PERM_SRC_*[j]
    localparam logic [4:0] PERM_SRC_FWD [24] = '{
        5'd0, 5'd4, 5'd8,  5'd12, 5'd16, 5'd20, 5'd1, 5'd5,
        5'd9, 5'd13, 5'd17, 5'd21, 5'd2, 5'd6, 5'd10, 5'd14,
        5'd18, 5'd22, 5'd3, 5'd7, 5'd11, 5'd15, 5'd19, 5'd23
    };
    localparam logic [4:0] PERM_SRC_INV [24] = '{
        5'd0, 5'd6, 5'd12, 5'd18, 5'd1, 5'd7, 5'd13, 5'd19,
        5'd2, 5'd8, 5'd14, 5'd20, 5'd3, 5'd9, 5'd15, 5'd21,
        5'd4, 5'd10, 5'd16, 5'd22, 5'd5, 5'd11, 5'd17, 5'd23
    };

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ks_step;  // store one round key, advance the key schedule
        logic load;     // take a new input word
        logic round;    // run one cipher step on the state
        logic finish;   // run the last step into the output register
    } t_dp_cmd;

    function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int n = 0; n < 6; n++) begin
            y[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int n = 0; n < 6; n++) begin
            y[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int j = 0; j < BLOCK_W; j++) begin
            y[j] = x[PERM_SRC_FWD[j]];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int j = 0; j < BLOCK_W; j++) begin
            y[j] = x[PERM_SRC_INV[j]];
        end
        return y;
    endfunction

endpackage

// ===== design/p24_ctrl.sv =====
module p24_ctrl #(
    parameter int NUM_ROUNDS = 10,
    localparam int CW = $clog2(NUM_ROUNDS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output p24_pkg::t_dp_cmd  o_cmd,
    output logic [CW-1:0]     o_cnt
);

    typedef enum logic [2:0] {
        ST_KEYGEN = 3'b001,
        ST_IDLE   = 3'b010,
        ST_RUN    = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_ovalid, n_ovalid;
    logic            w_last;
    logic            w_out_free;

    assign w_last     = (r_cnt == CW'(NUM_ROUNDS));
    assign w_out_free = ~r_ovalid | i_out_ready;

    // Sequence key schedule, rounds and output handoff
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ovalid   = r_ovalid & ~i_out_ready;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_KEYGEN: begin
                o_cmd.ks_step = 1'b1;
                if (w_last) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                    n_cnt      = '0;
                end
            end
            ST_RUN: begin
                if (!w_last) begin
                    o_cmd.round = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                end else if (w_out_free) begin
                    // hand off the result and take the next word in the same cycle
                    o_cmd.finish = 1'b1;
                    n_ovalid     = 1'b1;
                    o_in_ready   = 1'b1;
                    n_cnt        = '0;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_KEYGEN;
                n_cnt   = '0;
            end
        endcase
        // A key write restarts the key schedule
        if (i_cfg_we) begin
            n_state       = ST_KEYGEN;
            n_cnt         = '0;
            o_in_ready    = 1'b0;
            o_cmd.load    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_KEYGEN;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_cnt       = r_cnt;

endmodule

// ===== design/p24_dpath.sv =====
module p24_dpath #(
    parameter int NUM_ROUNDS = 10,
    localparam int CW = $clog2(NUM_ROUNDS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [p24_pkg::KEY_W-1:0]     i_cfg_wdata,
    input  p24_pkg::t_dp_cmd              i_cmd,
    input  logic [CW-1:0]                 i_cnt,
    input  logic                          i_action,
    input  logic [p24_pkg::BLOCK_W-1:0]   i_block,
    output logic [p24_pkg::BLOCK_W-1:0]   o_block
);

    localparam int RCW = p24_pkg::RC_W;
    localparam int BW  = p24_pkg::BLOCK_W;
    localparam int KSW = p24_pkg::KS_W;

    logic [p24_pkg::KEY_W-1:0]  r_cipher_key;
    logic [KSW-1:0]             r_ks;
    logic [BW-1:0]              r_rk [NUM_ROUNDS+1];
    logic [BW-1:0]              r_x;
    logic                       r_dec;
    logic [BW-1:0]              r_out;

    logic [KSW-1:0]             w_ks_cur;
    logic [KSW-1:0]             w_ks_rot;
    logic [KSW-1:0]             w_ks_next;
    logic [RCW-1:0]             w_rc;
    logic [CW-1:0]              w_kidx;
    logic [BW-1:0]              w_rk;
    logic                       w_plain;
    logic [BW-1:0]              w_step;

    // Key schedule: rotate right by 19, S-box the top nibble, add round counter
    assign w_ks_cur = (i_cnt == '0) ? {r_cipher_key, {(KSW - p24_pkg::KEY_W){1'b0}}} : r_ks;
    assign w_ks_rot = {w_ks_cur[18:0], w_ks_cur[KSW-1:19]};
    assign w_rc     = RCW'(i_cnt) + RCW'(1);
    always_comb begin
        w_ks_next              = w_ks_rot;
        w_ks_next[KSW-1 -: 4]  = p24_pkg::SBOX_FWD[w_ks_rot[KSW-1 -: 4]];
        w_ks_next[19:15]       = w_ks_rot[19:15] ^ w_rc;
    end

    // Encrypt walks keys upward, decrypt downward
    assign w_kidx  = r_dec ? (CW'(NUM_ROUNDS) - i_cnt) : i_cnt;
    assign w_rk    = r_rk[w_kidx];
    assign w_plain = r_dec ? (i_cnt == '0) : (i_cnt == CW'(NUM_ROUNDS));

    // One cipher step: bare key XOR at the outer end, full round otherwise
    always_comb begin
        if (w_plain) begin
            w_step = r_x ^ w_rk;
        end else if (r_dec) begin
            w_step = p24_pkg::sub_inv(p24_pkg::perm_inv(r_x)) ^ w_rk;
        end else begin
            w_step = p24_pkg::perm_fwd(p24_pkg::sub_fwd(r_x ^ w_rk));
        end
    end

    // Hold the master key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (i_cfg_we) begin
            r_cipher_key <= i_cfg_wdata;
        end
    end

    // Store round keys and advance the schedule register
    always_ff @(posedge i_clk) begin
        if (i_cmd.ks_step) begin
            r_rk[i_cnt] <= w_ks_cur[39:16];
            r_ks        <= w_ks_next;
        end
    end

    // Cipher state and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_block;
            r_dec <= i_action;
        end else if (i_cmd.round) begin
            r_x <= w_step;
        end
        if (i_cmd.finish) begin
            r_out <= w_step;
        end
    end

    assign o_block = r_out;

endmodule

// ===== design/present24_block_cipher.sv =====
// A word accepted on s_axis is loaded into the state register and passes the single
// round unit once per cycle; the last step is registered into the output register
// on m_axis_tdata. One word at a time: the next word is taken in the same cycle as
// the result is handed off. Reset (synchronous, active low) clears the key to zero,
// then the key schedule runs with s_axis_tready low; every key write repeats it.
module present24_block_cipher #(
    parameter int NUM_ROUNDS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [p24_pkg::KEY_W-1:0]     i_cfg_wdata,     // cipher_key
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [p24_pkg::BLOCK_W-1:0]   s_axis_tdata,    // [23:0] block_in
    input  logic [0:0]                    s_axis_tuser,    // [0] action (1 = decrypt)
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [p24_pkg::BLOCK_W-1:0]   m_axis_tdata     // [23:0] block_out
);

    localparam int CW = $clog2(NUM_ROUNDS + 1);

    p24_pkg::t_dp_cmd  w_cmd;
    logic [CW-1:0]     w_cnt;

    p24_ctrl #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .o_cnt       (w_cnt)
    );

    p24_dpath #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .i_cnt       (w_cnt),
        .i_action    (s_axis_tuser[0]),
        .i_block     (s_axis_tdata),
        .o_block     (m_axis_tdata)
    );

endmodule

// ===== design/p24_checker.sv =====
module p24_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [p24_pkg::BLOCK_W-1:0]   m_axis_tdata
);

    // Key schedule runs right after reset: no word taken, nothing shown
    a_reset_busy: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("block ready or output valid right after reset");

    // A key write blocks input while the schedule recomputes
    a_key_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("input ready right after a key write");

    // One word at a time: input closes after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready in the cycle after an accept");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word dropped or changed");

endmodule

bind present24_block_cipher p24_checker u_p24_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
